// File: sv/brb_pkg.sv
// shared types and constants for the byte ring buffer
`default_nettype none

package brb_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int MAX_REQUEST_DEF = 64;
    localparam int SIZE_RESET      = 256;

    localparam int W_OP   = 3;
    localparam int W_CNT  = 7;
    localparam int W_BYTE = 8;
    localparam int W_LVL  = 9;

    typedef enum logic [W_OP-1:0] {
        OP_WRITE_START = 3'd0,
        OP_WRITE_BYTE  = 3'd1,
        OP_READ        = 3'd2,
        OP_PEEK        = 3'd3,
        OP_ADVANCE     = 3'd4,
        OP_CLEAR       = 3'd5
    } t_op;

    typedef struct packed {
        logic [W_OP-1:0]   operation;
        logic [W_CNT-1:0]  count;
        logic [W_BYTE-1:0] data_in;
    } t_in_beat;

    typedef struct packed {
        logic [W_BYTE-1:0] data_out;
        logic              byte_valid;
        logic              last;
        logic              accepted;
        logic [W_CNT-1:0]  moved_count;
        logic [W_LVL-1:0]  fill_level;
        logic [W_LVL-1:0]  free_space;
    } t_out_beat;

endpackage

`default_nettype wire

// File: sv/byte_ring_buffer_peek_advance.sv
// byte ring buffer top level: sequencer, state registers and result register
//
// Input channel i_in (valid/ready) takes one operation per beat: write_start,
// write_byte, read, peek, advance or clear. Output channel o_out (valid/ready)
// gives one status beat per operation, or one beat per byte for read and peek,
// with last set on the final beat. Every beat carries fill level and free
// space after the whole operation.
// Sequencing: an item is taken when the block is idle. It passes through
// EXEC to OUT, where its single result beat is presented; read and peek
// with bytes to move instead go from EXEC through RD_ADDR, RD_DATA and OUT
// for every byte emitted. A new item is taken only after the last beat of
// the current one. The sequencer shares one wrap-around adder and one storage
// port for index steps and byte reads.
// While a result beat waits on a stalled receiver, the sequencer holds and
// no new item is taken. i_cfg_we writes buffer_size at once and empties the
// buffer; write it only while idle. Synchronous reset empties the buffer and
// sets buffer_size to SIZE_RESET capped at DEPTH; storage content is not cleared.
`default_nettype none

module byte_ring_buffer_peek_advance #(
    parameter int DEPTH       = brb_pkg::DEPTH_DEF,
    parameter int MAX_REQUEST = brb_pkg::MAX_REQUEST_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire brb_pkg::t_in_beat       i_in,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output brb_pkg::t_out_beat           o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [brb_pkg::W_LVL-1:0] i_cfg_data
);
    import brb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > W_LVL) ? CW : W_LVL;
    localparam int MW = (CW > W_CNT) ? CW : W_CNT;
    localparam logic [CW-1:0] RESET_SIZE =
        (SIZE_RESET > DEPTH) ? CW'(DEPTH) : CW'(SIZE_RESET);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXEC    = 5'b00010,
        S_RD_ADDR = 5'b00100,
        S_RD_DATA = 5'b01000,
        S_OUT     = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_held, n_held;
    logic [CW-1:0]     r_size, n_size;
    logic [W_CNT-1:0]  r_resv, n_resv;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [W_CNT-1:0]  r_left, n_left;
    logic [W_OP-1:0]   r_op, n_op;
    logic [W_CNT-1:0]  r_cnt, n_cnt;
    logic [W_BYTE-1:0] r_din, n_din;
    logic [W_BYTE-1:0] r_data, n_data;
    logic              r_bval, n_bval;
    logic              r_last, n_last;
    logic              r_acc, n_acc;
    logic [W_CNT-1:0]  r_moved, n_moved;

    logic [AW-1:0]     wa_idx;
    logic [CW-1:0]     wa_off;
    logic [AW-1:0]     wa_pos;
    logic [MW-1:0]     held_w;
    logic [MW-1:0]     cnt_w;
    logic [MW-1:0]     free_w;
    logic [MW-1:0]     take_w;
    logic [W_CNT-1:0]  in_cnt;
    logic [SW-1:0]     cfg_w;
    logic [CW-1:0]     cfg_eff;
    logic              wb_ok;
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [W_BYTE-1:0] mem_rdata;
    logic [SW-1:0]     fill_w;
    logic [SW-1:0]     spare_w;

    brb_wrap #(
        .AW (AW),
        .CW (CW)
    ) u_wrap (
        .i_idx  (wa_idx),
        .i_off  (wa_off),
        .i_size (r_size),
        .o_pos  (wa_pos)
    );

    brb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_din),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        held_w = MW'(r_held);
        cnt_w  = MW'(r_cnt);
        free_w = MW'(r_size - r_held);
        take_w = (cnt_w < held_w) ? cnt_w : held_w;
        wb_ok  = (r_resv != '0) && (r_held < r_size);
        in_cnt = (i_in.count > W_CNT'(MAX_REQUEST)) ? W_CNT'(MAX_REQUEST) : i_in.count;
        cfg_w  = SW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            cfg_eff = CW'(1);
        end else if (cfg_w > SW'(DEPTH)) begin
            cfg_eff = CW'(DEPTH);
        end else begin
            cfg_eff = cfg_w[CW-1:0];
        end
    end

    // wrap adder operand select
    always_comb begin
        wa_idx = r_head;
        wa_off = r_held;
        if (r_state == S_RD_ADDR) begin
            wa_idx = r_ptr;
            wa_off = CW'(1);
        end else if (r_op != OP_WRITE_BYTE) begin
            wa_off = take_w[CW-1:0];
        end
    end

    always_comb begin
        mem_we   = (r_state == S_EXEC) && (r_op == OP_WRITE_BYTE) && wb_ok;
        mem_en   = mem_we || (r_state == S_RD_ADDR);
        mem_addr = mem_we ? wa_pos : r_ptr;
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_held  = r_held;
        n_size  = r_size;
        n_resv  = r_resv;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_din   = r_din;
        n_data  = r_data;
        n_bval  = r_bval;
        n_last  = r_last;
        n_acc   = r_acc;
        n_moved = r_moved;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.operation;
                    n_cnt   = in_cnt;
                    n_din   = i_in.data_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_data  = '0;
                n_bval  = 1'b0;
                n_last  = 1'b1;
                n_acc   = 1'b0;
                n_moved = '0;
                n_state = S_OUT;
                case (t_op'(r_op))
                    OP_WRITE_START: begin
                        if (cnt_w < free_w) begin
                            n_resv  = r_cnt;
                            n_acc   = 1'b1;
                            n_moved = r_cnt;
                        end else begin
                            n_resv = '0;
                        end
                    end
                    OP_WRITE_BYTE: begin
                        if (wb_ok) begin
                            n_held = r_held + CW'(1);
                            n_resv = r_resv - W_CNT'(1);
                            n_acc  = 1'b1;
                        end
                    end
                    OP_READ, OP_PEEK: begin
                        n_moved = take_w[W_CNT-1:0];
                        n_left  = take_w[W_CNT-1:0];
                        n_ptr   = r_head;
                        if (r_op == OP_READ) begin
                            n_head = wa_pos;
                            n_held = r_held - take_w[CW-1:0];
                        end
                        if (take_w != '0) begin
                            n_state = S_RD_ADDR;
                        end
                    end
                    OP_ADVANCE: begin
                        n_moved = take_w[W_CNT-1:0];
                        n_head  = wa_pos;
                        n_held  = r_held - take_w[CW-1:0];
                    end
                    OP_CLEAR: begin
                        n_head = '0;
                        n_held = '0;
                        n_resv = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_ADDR: begin
                n_ptr   = wa_pos;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_data  = mem_rdata;
                n_bval  = 1'b1;
                n_last  = (r_left == W_CNT'(1));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - W_CNT'(1);
                        n_state = S_RD_ADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_size = cfg_eff;
            n_head = '0;
            n_held = '0;
            n_resv = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_held  <= '0;
            r_size  <= RESET_SIZE;
            r_resv  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_held  <= n_held;
            r_size  <= n_size;
            r_resv  <= n_resv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_left  <= n_left;
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_din   <= n_din;
        r_data  <= n_data;
        r_bval  <= n_bval;
        r_last  <= n_last;
        r_acc   <= n_acc;
        r_moved <= n_moved;
    end

    always_comb begin
        fill_w            = SW'(r_held);
        spare_w           = SW'(r_size - r_held);
        o_in_ready        = (r_state == S_IDLE);
        o_out_valid       = (r_state == S_OUT);
        o_out.data_out    = r_data;
        o_out.byte_valid  = r_bval;
        o_out.last        = r_last;
        o_out.accepted    = r_acc;
        o_out.moved_count = r_moved;
        o_out.fill_level  = fill_w[W_LVL-1:0];
        o_out.free_space  = spare_w[W_LVL-1:0];
    end

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result beat is pending");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_size)
        else $error("fill level above buffer size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting an item");

    a_byte_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.byte_valid) |-> (o_out.moved_count != '0))
        else $error("data beat with zero moved count");
`endif

endmodule

`default_nettype wire

// File: sv/brb_wrap.sv
// shared wrap-around index adder
`default_nettype none

module brb_wrap #(
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  wire logic [AW-1:0] i_idx,
    input  wire logic [CW-1:0] i_off,
    input  wire logic [CW-1:0] i_size,
    output logic      [AW-1:0] o_pos
);
    localparam int W = CW + 1;

    logic [W-1:0] sum;
    logic [W-1:0] size_w;
    logic [W-1:0] once;

    always_comb begin
        size_w = W'(i_size);
        sum    = W'(i_idx) + W'(i_off);
        once   = (sum >= size_w) ? (sum - size_w) : sum;
        o_pos  = (once >= size_w) ? '0 : once[AW-1:0];
    end

endmodule

`default_nettype wire

// File: sv/brb_store.sv
// single-port byte storage with registered read
`default_nettype none

module brb_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire
